// ===== rtl/cqd_pkg.sv =====
// Shared constants, types and helper functions of the circular queue.
package cqd_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH);
  localparam int CAP_W  = 7;
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_PRINT  = 2'd2;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_LISTED   = 3'd4;

  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic delete;
    logic print_start;
    logic print_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_empty;
    logic print_fin;
    logic out_free;
  } sts_t;

  // zero maps to one, anything above DEPTH saturates
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] c;
    c = raw;
    if (c == '0) c = CAP_W'(1);
    if (c > CAP_MAX) c = CAP_MAX;
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                  input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + CAP_W'(1);
    if (n >= cap) n = '0;
    return n[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/cqd_if.sv =====
// Valid/ready channel interfaces: operation input, result output, capacity write.
interface cqd_in_if;
  logic                              valid;
  logic                              ready;
  logic [cqd_pkg::OP_W-1:0]          operation;
  logic signed [cqd_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cqd_out_if;
  logic                              valid;
  logic                              ready;
  logic [cqd_pkg::ST_W-1:0]          status;
  logic signed [cqd_pkg::DATA_W-1:0] element;
  logic                              last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

interface cqd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cqd_pkg::CAP_W-1:0]       data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cqd_ctrl.sv =====
// Controller: accepts operation items and sequences print streaming.
module cqd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [cqd_pkg::OP_W-1:0] in_op_i,
  output logic                     in_ready_o,
  input  cqd_pkg::sts_t            sts_i,
  output cqd_pkg::cmd_t            cmd_o
);
  import cqd_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PRINT = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.insert      = accept && (in_op_i == OP_INSERT);
    cmd_o.delete      = accept && (in_op_i == OP_DELETE);
    cmd_o.print_start = accept && (in_op_i == OP_PRINT);
    cmd_o.print_step  = (state_q == S_PRINT) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.print_start && !sts_i.is_empty) state_d = S_PRINT;
      end
      S_PRINT: begin
        if (cmd_o.print_step && sts_i.print_fin) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_print_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.print_start && !sts_i.is_empty) |=> (state_q == S_PRINT))
    else $error("print of a non-empty queue did not start streaming");

  a_no_accept_in_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRINT) |-> !(cmd_o.insert || cmd_o.delete || cmd_o.print_start))
    else $error("operation taken while a print is streaming");

endmodule

// ===== rtl/cqd_dp.sv =====
// Datapath: storage memory, head/tail/empty state, capacity and result register.
module cqd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cqd_pkg::cmd_t                     cmd_i,
  output cqd_pkg::sts_t                     sts_o,
  input  logic signed [cqd_pkg::DATA_W-1:0] in_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cqd_pkg::CAP_W-1:0]         cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cqd_pkg::ST_W-1:0]          out_status_o,
  output logic signed [cqd_pkg::DATA_W-1:0] out_element_o,
  output logic                              out_last_o
);
  import cqd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             empty_q, empty_d;

  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q, out_status_d;
  logic [DATA_W-1:0] out_elem_q, out_elem_d;
  logic             out_last_q, out_last_d;
  logic             load_out;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [IDX_W-1:0] tail_nx, head_nx, ptr_nx;
  logic             cfg_wr, fin;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign tail_nx = wrap_next(tail_q, cap_q);
  assign head_nx = wrap_next(head_q, cap_q);
  assign ptr_nx  = wrap_next(ptr_q, cap_q);
  assign fin     = (ptr_q == tail_q) || (cnt_q == CNT_W'(DEPTH - 1));

  assign sts_o.is_empty  = empty_q;
  assign sts_o.print_fin = fin;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cap_d        = cap_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    wr_en        = 1'b0;
    wr_addr      = '0;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    load_out     = 1'b0;
    out_status_d = ST_EMPTY;
    out_elem_d   = '0;
    out_last_d   = 1'b1;

    if (cmd_i.insert) begin
      load_out     = 1'b1;
      out_status_d = ST_INSERTED;
      if (empty_q) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
      end else if (tail_nx == head_q) begin
        out_status_d = ST_FULL;
      end else begin
        wr_en   = 1'b1;
        wr_addr = tail_nx;
        tail_d  = tail_nx;
      end
    end

    if (cmd_i.delete) begin
      load_out = 1'b1;
      if (empty_q) begin
        out_status_d = ST_EMPTY;
      end else begin
        out_status_d = ST_DELETED;
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          head_d = head_nx;
        end
      end
    end

    if (cmd_i.print_start) begin
      if (empty_q) begin
        load_out     = 1'b1;
        out_status_d = ST_EMPTY;
      end else begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        ptr_d   = head_q;
        cnt_d   = '0;
      end
    end

    // hand out the fetched entry and prefetch the next one
    if (cmd_i.print_step) begin
      load_out     = 1'b1;
      out_status_d = ST_LISTED;
      out_elem_d   = rdata_q;
      out_last_d   = fin;
      if (!fin) begin
        rd_en   = 1'b1;
        rd_addr = ptr_nx;
        ptr_d   = ptr_nx;
        cnt_d   = cnt_q + CNT_W'(1);
      end
    end

    // capacity write also empties the queue
    if (cfg_wr) begin
      cap_d   = eff_cap(cfg_data_i);
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= in_value_i;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_MAX;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    cnt_q <= cnt_d;
    if (load_out) begin
      out_status_q <= out_status_d;
      out_elem_q   <= out_elem_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_elem_q;
  assign out_last_o    = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load_out)
    else $error("result register loaded while a result is stalled");

  a_idx_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> ((CAP_W'(head_q) < cap_q) && (CAP_W'(tail_q) < cap_q)))
    else $error("head or tail outside capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CAP_MAX))
    else $error("capacity register out of range");

endmodule

// ===== rtl/circular_queue_with_dump_core.sv =====
// Top level of the circular queue with print-all dump.
//
//  channel  modport  payload                     accepted at
//  in_i     sink     operation, value            valid && ready
//  out_o    source   status, element, last       valid && ready
//  cfg_i    sink     data (capacity)             valid && ready
//
// Insert and delete results appear in the output register in the cycle after acceptance.
// Print of N entries streams one entry per cycle while the output is free, from the storage
// read port via a prefetch register; input stays blocked until the last entry is registered.
// Output stalls hold the result register and freeze printing; cfg is always ready.
// Reset: queue empty, capacity 64; storage contents are not cleared.
module circular_queue_with_dump_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cqd_in_if.sink     in_i,
  cqd_out_if.source  out_o,
  cqd_cfg_if.sink    cfg_i
);
  import cqd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_value_i    (in_i.value),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_ready_o   (cfg_i.ready),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_status_o  (out_o.status),
    .out_element_o (out_o.element),
    .out_last_o    (out_o.last)
  );

endmodule

// ===== tb/circular_queue_with_dump_checker.sv =====
`timescale 1ns / 100ps
// Queue predictor and result comparator, watching the operation, result and capacity channels.
module circular_queue_with_dump_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqd_in_if           in_i,
  cqd_out_if          out_i,
  cqd_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_seen_o
);
  import cqd_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } queue_result_t;

  queue_result_t            expected_q[$];
  logic signed [DATA_W-1:0] slot_mem [DEPTH];
  logic [IDX_W-1:0]         head_idx;
  logic [IDX_W-1:0]         tail_idx;
  logic                     queue_empty;
  logic [CAP_W-1:0]         cap_raw;

  // zero behaves as one slot, anything past DEPTH is clipped
  function automatic logic [CAP_W-1:0] slots_in_use();
    if (cap_raw == '0) return CAP_W'(1);
    if (cap_raw > CAP_W'(DEPTH)) return CAP_W'(DEPTH);
    return cap_raw;
  endfunction

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + CAP_W'(1);
    if (n >= slots_in_use()) n = '0;
    return n[IDX_W-1:0];
  endfunction

  task automatic expect_result(input logic [ST_W-1:0] st, input logic signed [DATA_W-1:0] el,
                               input logic lst);
    queue_result_t r;
    r.status  = st;
    r.element = el;
    r.last    = lst;
    expected_q.push_back(r);
  endtask

  task automatic clear_queue();
    head_idx    = '0;
    tail_idx    = '0;
    queue_empty = 1'b1;
  endtask

  task automatic predict_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] idx;
    int unsigned      k;
    logic             fin;
    case (op)
      OP_INSERT: begin
        if (queue_empty) begin
          slot_mem[0] = val;
          head_idx    = '0;
          tail_idx    = '0;
          queue_empty = 1'b0;
          expect_result(ST_INSERTED, '0, 1'b1);
        end else begin
          nxt = step_index(tail_idx);
          if (nxt == head_idx) begin
            expect_result(ST_FULL, '0, 1'b1);
          end else begin
            slot_mem[nxt] = val;
            tail_idx      = nxt;
            expect_result(ST_INSERTED, '0, 1'b1);
          end
        end
      end
      OP_DELETE: begin
        if (queue_empty) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (head_idx == tail_idx) clear_queue();
          else head_idx = step_index(head_idx);
          expect_result(ST_DELETED, '0, 1'b1);
        end
      end
      OP_PRINT: begin
        if (queue_empty) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = head_idx;
          k   = 0;
          fin = 1'b0;
          while (!fin) begin
            fin = (idx == tail_idx) || (k == DEPTH - 1);
            expect_result(ST_LISTED, slot_mem[idx], fin);
            k++;
            idx = step_index(idx);
          end
        end
      end
      default: ; // unused code: no result, state kept
    endcase
  endtask

  task automatic compare_result();
    queue_result_t want;
    results_seen_o++;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: status=%0d element=%0d last=%0d",
             out_i.status, out_i.element, out_i.last);
      fail_count_o++;
    end else begin
      want = expected_q.pop_front();
      if (want.status !== out_i.status) begin
        $error("status: expected %0d, got %0d", want.status, out_i.status);
        fail_count_o++;
      end
      if (want.element !== out_i.element) begin
        $error("element: expected %0d, got %0d", want.element, out_i.element);
        fail_count_o++;
      end
      if (want.last !== out_i.last) begin
        $error("last: expected %0d, got %0d", want.last, out_i.last);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      clear_queue();
      cap_raw        = CAP_W'(DEPTH);
      fail_count_o   = 0;
      pending_o      = 0;
      results_seen_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) compare_result();
      // a capacity write also empties the queue
      if (cfg_i.valid && cfg_i.ready) begin
        cap_raw = cfg_i.data;
        clear_queue();
      end
      if (in_i.valid && in_i.ready) predict_item(in_i.operation, in_i.value);
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/circular_queue_with_dump_core_test.sv =====
`timescale 1ns / 100ps
// Stimulus, handshake idling and verdict for the circular queue core.
module circular_queue_with_dump_core_test;
  import cqd_pkg::*;

  localparam int unsigned      CYCLE_LIMIT   = 1000000;
  localparam int unsigned      MAX_WAIT      = 10;
  localparam int unsigned      SETTLE_CYCLES = 6;
  localparam int unsigned      PHASE_ITEMS   = 20;
  localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          no_idle;
  int unsigned items_sent;
  int unsigned cap_writes;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;

  cqd_in_if  in_ch ();
  cqd_out_if out_ch ();
  cqd_cfg_if cfg_ch ();

  circular_queue_with_dump_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  circular_queue_with_dump_checker queue_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .cfg_i          (cfg_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  always begin
    #1;
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stall before each item, none in no-idle stretches
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // entered and left at a falling edge; valid stays high when the next item follows at once
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.value     = val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // block idle: all results back, plus a settling wait for items that give none
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = cap;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
    cap_writes++;
  endtask

  function automatic logic [OP_W-1:0] pick_op(input int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return OP_INSERT;
    if (r < insert_pct + (90 - insert_pct) / 2) return OP_DELETE;
    if (r < 97) return OP_PRINT;
    return OP_UNUSED;
  endfunction

  // first half leans to inserts so the queue fills and wraps, second half takes inserts and deletes equally
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n);
    write_capacity(cap);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(pick_op((i < n / 2) ? 70 : 30), $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] sweep_caps [7];
    rst_ni          = 1'b0;
    no_idle         = 1'b0;
    items_sent      = 0;
    cap_writes      = 0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.value     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty queue at reset capacity, then extreme words
    send_item(OP_PRINT, '0);
    send_item(OP_DELETE, 32'hffff_ffff);
    send_item(OP_UNUSED, 32'h5a5a_a5a5);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_PRINT, 32'hffff_ffff);
    for (int unsigned i = 0; i < 4; i++) send_item(OP_DELETE, '0);
    send_item(OP_DELETE, '0);
    send_item(OP_INSERT, 32'h1234_5678);
    send_item(OP_PRINT, '0);

    // zero capacity acts as a single slot; the write also drops the stored word
    write_capacity('0);
    send_item(OP_INSERT, 32'hdead_beef);
    send_item(OP_INSERT, 32'h0bad_f00d);
    send_item(OP_PRINT, '0);
    send_item(OP_DELETE, '0);

    // full depth: fill, full report, 64-entry listing, then wrap the tail
    write_capacity(CAP_W'(DEPTH));
    no_idle = ($urandom_range(0, 1) == 0);
    for (int unsigned i = 0; i <= DEPTH; i++) send_item(OP_INSERT, $urandom);
    send_item(OP_PRINT, $urandom);
    for (int unsigned i = 0; i < 3; i++) send_item(OP_DELETE, $urandom);
    for (int unsigned i = 0; i < 3; i++) send_item(OP_INSERT, $urandom);
    send_item(OP_PRINT, $urandom);

    sweep_caps    = '{7'd127, 7'd2, 7'd3, 7'd65, 7'd7, 7'd1, 7'd1};
    sweep_caps[5] = CAP_W'($urandom_range(1, 127));
    for (int unsigned p = 0; p < 7; p++) run_phase(sweep_caps[p], PHASE_ITEMS);

    settle();
    $display("%0d operations sent over %0d capacity writes, %0d results compared",
             items_sent, cap_writes, results_seen);
    $display("capacities from zero to 127 covered, with fill, wrap, full and empty cases");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cqd_pkg.sv
rtl/cqd_if.sv
rtl/cqd_ctrl.sv
rtl/cqd_dp.sv
rtl/circular_queue_with_dump_core.sv
tb/circular_queue_with_dump_checker.sv
tb/circular_queue_with_dump_core_test.sv
